// ===== hw/rtl/v3n_pkg.sv =====
// shared constants and types for the vector normalize core
`default_nettype none
package v3n_pkg;
  localparam int COMP_W     = 16;
  localparam int SUM_W      = 32;
  localparam int MAG_W      = 24;
  localparam int SQ_REM_W   = 26;
  localparam int DIV_REM_W  = 25;
  localparam int QUO_W      = 15;
  localparam int SQ_STAGES  = 24;
  localparam int DIV_STAGES = 15;
  localparam int DIV_PRESHIFT = 7;
  localparam logic [QUO_W-1:0] UNIT_ONE = 15'd16384;

  typedef struct packed {
    logic [COMP_W-1:0] ax;
    logic [COMP_W-1:0] ay;
    logic [COMP_W-1:0] az;
    logic [2:0]        neg;
  } side_t;
endpackage
`default_nettype wire

// ===== hw/rtl/v3n_sqrt_cell.sv =====
// one square root cell: settles one root bit per item
`default_nettype none
module v3n_sqrt_cell (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [v3n_pkg::SQ_REM_W-1:0]  rem_i,
  input  wire logic [v3n_pkg::MAG_W-1:0]     root_i,
  input  wire logic [v3n_pkg::SUM_W-1:0]     rad_i,
  output logic      [v3n_pkg::SQ_REM_W-1:0]  rem_r,
  output logic      [v3n_pkg::MAG_W-1:0]     root_r,
  output logic      [v3n_pkg::SUM_W-1:0]     rad_r
);
  logic [v3n_pkg::SQ_REM_W+1:0] cur;
  logic [v3n_pkg::SQ_REM_W+1:0] trial;
  logic                         ge;
  logic [v3n_pkg::SQ_REM_W+1:0] diff;

  always_comb begin
    cur   = {rem_i, rad_i[v3n_pkg::SUM_W-1 -: 2]};
    trial = {2'b00, root_i, 2'b01};
    ge    = (cur >= trial);
    diff  = cur - trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= ge ? diff[v3n_pkg::SQ_REM_W-1:0] : cur[v3n_pkg::SQ_REM_W-1:0];
      root_r <= {root_i[v3n_pkg::MAG_W-2:0], ge};
      rad_r  <= {rad_i[v3n_pkg::SUM_W-3:0], 2'b00};
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/v3n_div_cell.sv =====
// one restoring divide cell: settles one quotient bit per item
`default_nettype none
module v3n_div_cell (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [v3n_pkg::DIV_REM_W-1:0] rem_i,
  input  wire logic [v3n_pkg::QUO_W-1:0]     quo_i,
  input  wire logic [v3n_pkg::MAG_W-1:0]     div_i,
  output logic      [v3n_pkg::DIV_REM_W-1:0] rem_r,
  output logic      [v3n_pkg::QUO_W-1:0]     quo_r
);
  logic [v3n_pkg::DIV_REM_W:0] cur;
  logic [v3n_pkg::DIV_REM_W:0] dv;
  logic                        ge;
  logic [v3n_pkg::DIV_REM_W:0] diff;

  always_comb begin
    cur  = {rem_i, 1'b0};
    dv   = {2'b00, div_i};
    ge   = (cur >= dv);
    diff = cur - dv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= ge ? diff[v3n_pkg::DIV_REM_W-1:0] : cur[v3n_pkg::DIV_REM_W-1:0];
      quo_r <= {quo_i[v3n_pkg::QUO_W-2:0], ge};
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/vector3_normalize_core.sv =====
// top level of the 3d vector normalize core: length and unit vector
`default_nettype none
// Takes one signed Q8.8 vector per cycle while in_ready is high and returns its
// length (units of 2^-16, floor of the square root) and its unit vector in Q1.14,
// truncated toward zero and saturated to +/-16384. A zero vector sets zero_vector
// and gives zero outputs. Throughput is one item per clock while the chain
// advances. The path runs from a squaring register through a chain of 24 square
// root cells (one root bit each) and a chain of 15 divide cells (one quotient
// bit for all three components each) to the output register. The whole
// chain moves together; it keeps moving while the output register holds an
// untaken item as long as the last cell is empty.
module vector3_normalize_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_comp_x,
  input  wire logic [15:0] in_comp_y,
  input  wire logic [15:0] in_comp_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_unit_x,
  output logic [15:0]      out_unit_y,
  output logic [15:0]      out_unit_z,
  output logic [23:0]      out_magnitude,
  output logic             out_zero_vector
);
  localparam int SQ_N  = v3n_pkg::SQ_STAGES;
  localparam int DV_N  = v3n_pkg::DIV_STAGES;
  localparam int LAST  = SQ_N + DV_N;

  // valid bit per chain position: 0 is the squaring register
  logic [LAST:0] v_r;
  logic          adv;
  logic          out_valid_r;

  // squaring stage
  v3n_pkg::side_t              s0_side_r;
  logic [v3n_pkg::SUM_W-1:0]   sum_r;
  v3n_pkg::side_t              in_side;
  logic [v3n_pkg::SUM_W-1:0]   sum_nxt;

  // square root chain
  logic [v3n_pkg::SQ_REM_W-1:0] sq_rem  [0:SQ_N];
  logic [v3n_pkg::MAG_W-1:0]    sq_root [0:SQ_N];
  logic [v3n_pkg::SUM_W-1:0]    sq_rad  [0:SQ_N];
  v3n_pkg::side_t               sq_side_r [1:SQ_N];

  // divide chain, three lanes
  logic [v3n_pkg::DIV_REM_W-1:0] dv_rem [0:2][0:DV_N];
  logic [v3n_pkg::QUO_W-1:0]     dv_quo [0:2][0:DV_N];
  logic [v3n_pkg::MAG_W-1:0]     dv_mag_r [1:DV_N];
  logic [2:0]                    dv_neg_r [1:DV_N];
  logic [v3n_pkg::MAG_W-1:0]     dv_mag [0:DV_N];

  // output register
  logic [15:0] ux_r, uy_r, uz_r;
  logic [23:0] mag_r;
  logic        zero_r;
  logic [15:0] ux_nxt, uy_nxt, uz_nxt;
  logic        zero_nxt;

  // chain advances unless a held result would be overwritten by a live item
  assign adv      = !out_valid_r || out_ready || !v_r[LAST];
  assign in_ready = adv;

  // magnitude of each component, -32768 maps to 32768
  always_comb begin
    in_side.ax  = in_comp_x[15] ? 16'(-in_comp_x) : in_comp_x;
    in_side.ay  = in_comp_y[15] ? 16'(-in_comp_y) : in_comp_y;
    in_side.az  = in_comp_z[15] ? 16'(-in_comp_z) : in_comp_z;
    in_side.neg = {in_comp_z[15], in_comp_y[15], in_comp_x[15]};
    sum_nxt = 32'(in_side.ax * in_side.ax) + 32'(in_side.ay * in_side.ay)
            + 32'(in_side.az * in_side.az);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[LAST-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_side_r <= in_side;
      sum_r     <= sum_nxt;
    end
  end

  // root of sum * 2^16: sum bits feed the first 16 cells, zeros the rest
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = sum_r;

  for (genvar k = 0; k < SQ_N; k++) begin : g_sq
    v3n_sqrt_cell u_cell (
      .clk    (clk),
      .en     (adv),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rad_i  (sq_rad[k]),
      .rem_r  (sq_rem[k+1]),
      .root_r (sq_root[k+1]),
      .rad_r  (sq_rad[k+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_side_r[k+1] <= (k == 0) ? s0_side_r : sq_side_r[(k == 0) ? 1 : k];
      end
    end
  end

  // |comp| * 2^22 / mag: quotient stays below 2^15, so start from |comp| << 7
  assign dv_mag[0] = sq_root[SQ_N];
  assign dv_rem[0][0] = {2'b00, sq_side_r[SQ_N].ax, {v3n_pkg::DIV_PRESHIFT{1'b0}}};
  assign dv_rem[1][0] = {2'b00, sq_side_r[SQ_N].ay, {v3n_pkg::DIV_PRESHIFT{1'b0}}};
  assign dv_rem[2][0] = {2'b00, sq_side_r[SQ_N].az, {v3n_pkg::DIV_PRESHIFT{1'b0}}};
  assign dv_quo[0][0] = '0;
  assign dv_quo[1][0] = '0;
  assign dv_quo[2][0] = '0;

  for (genvar j = 0; j < DV_N; j++) begin : g_dv
    for (genvar l = 0; l < 3; l++) begin : g_lane
      v3n_div_cell u_cell (
        .clk   (clk),
        .en    (adv),
        .rem_i (dv_rem[l][j]),
        .quo_i (dv_quo[l][j]),
        .div_i (dv_mag[j]),
        .rem_r (dv_rem[l][j+1]),
        .quo_r (dv_quo[l][j+1])
      );
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_mag_r[j+1] <= dv_mag[j];
        dv_neg_r[j+1] <= (j == 0) ? sq_side_r[SQ_N].neg : dv_neg_r[(j == 0) ? 1 : j];
      end
    end
    assign dv_mag[j+1] = dv_mag_r[j+1];
  end

  // saturate, restore sign, zero vector override
  function automatic logic [15:0] v3n_unit(input logic [v3n_pkg::QUO_W-1:0] q,
                                           input logic neg, input logic zero);
    logic [v3n_pkg::QUO_W-1:0] qs;
    logic [15:0]               mag16;
    qs    = (q > v3n_pkg::UNIT_ONE) ? v3n_pkg::UNIT_ONE : q;
    mag16 = {1'b0, qs};
    if (zero) begin
      return '0;
    end
    return neg ? 16'(-mag16) : mag16;
  endfunction

  always_comb begin
    zero_nxt = (dv_mag[DV_N] == '0);
    ux_nxt   = v3n_unit(dv_quo[0][DV_N], dv_neg_r[DV_N][0], zero_nxt);
    uy_nxt   = v3n_unit(dv_quo[1][DV_N], dv_neg_r[DV_N][1], zero_nxt);
    uz_nxt   = v3n_unit(dv_quo[2][DV_N], dv_neg_r[DV_N][2], zero_nxt);
  end

  // output register loads whenever it is free or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= v_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      ux_r   <= ux_nxt;
      uy_r   <= uy_nxt;
      uz_r   <= uz_nxt;
      mag_r  <= dv_mag[DV_N];
      zero_r <= zero_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_unit_x      = ux_r;
  assign out_unit_y      = uy_r;
  assign out_unit_z      = uz_r;
  assign out_magnitude   = mag_r;
  assign out_zero_vector = zero_r;
endmodule
`default_nettype wire

// ===== bench/tb_vector3_normalize_core.sv =====
// testbench for the vector normalize core: directed table, random vectors, scoreboard
`default_nettype none
module tb_vector3_normalize_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAT_CYCLES = 41;
  localparam int MAX_CYCLES = 400000;
  localparam int N_RANDOM   = 600;

  typedef struct packed {
    logic [15:0] ux;
    logic [15:0] uy;
    logic [15:0] uz;
    logic [23:0] mag;
    logic        zv;
  } norm_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    bit          known;  // expected result typed in below
    norm_t       res;
  } vec_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_comp_x = '0;
  logic [15:0] in_comp_y = '0;
  logic [15:0] in_comp_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_unit_x;
  logic [15:0] out_unit_y;
  logic [15:0] out_unit_z;
  logic [23:0] out_magnitude;
  logic        out_zero_vector;

  norm_t norm_q[$];
  int    n_fail = 0;
  int    cycle_cnt = 0;
  int    in_idle_pct = 27;
  int    out_idle_pct = 70;
  bit    out_hold = 1'b0;

  vector3_normalize_core u_dut (.*);

  always #5 clk = ~clk;

  // magnitude of a component, full scale included
  function automatic logic [16:0] comp_abs(logic [15:0] c);
    return c[15] ? 17'h10000 - {1'b0, c} : {1'b0, c};
  endfunction

  // digit-by-digit floor square root of a 48-bit value
  function automatic logic [23:0] root48(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 48;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root[23:0];
  endfunction

  // signed unit component: truncate toward zero, then saturate
  function automatic logic [15:0] unit_of(logic [15:0] c, logic [23:0] mag);
    logic [63:0] q;
    q = ({47'd0, comp_abs(c)} << 22) / mag;
    if (q > 64'd16384) q = 64'd16384;
    return c[15] ? 16'(17'h10000 - q[16:0]) : q[15:0];
  endfunction

  function automatic norm_t normalize(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    norm_t r;
    logic [63:0] sum;
    sum = comp_abs(x) * comp_abs(x) + comp_abs(y) * comp_abs(y)
        + comp_abs(z) * comp_abs(z);
    r.mag = root48(sum << 16);
    if (r.mag == 0) begin
      r = '0;
      r.zv = 1'b1;
    end else begin
      r.ux = unit_of(x, r.mag);
      r.uy = unit_of(y, r.mag);
      r.uz = unit_of(z, r.mag);
      r.zv = 1'b0;
    end
    return r;
  endfunction

  // directed table: zero vector, axis extremes, saturation, mixed signs
  vec_row_t dir_tbl[] = '{
    '{16'h0000, 16'h0000, 16'h0000, 1, '{16'd0, 16'd0, 16'd0, 24'd0, 1'b1}},
    '{16'h0100, 16'h0000, 16'h0000, 1, '{16'd16384, 16'd0, 16'd0, 24'd65536, 1'b0}},
    '{16'h0000, 16'hff00, 16'h0000, 1, '{16'd0, 16'hc000, 16'd0, 24'd65536, 1'b0}},
    '{16'h0000, 16'h0000, 16'h8000, 1, '{16'd0, 16'd0, 16'hc000, 24'd8388608, 1'b0}},
    '{16'h7fff, 16'h0000, 16'h0000, 1, '{16'd16384, 16'd0, 16'd0, 24'd8388352, 1'b0}},
    '{16'h0001, 16'h0000, 16'h0000, 1, '{16'd16384, 16'd0, 16'd0, 24'd256, 1'b0}},
    '{16'h8000, 16'h8000, 16'h8000, 0, '0},
    '{16'h7fff, 16'h7fff, 16'h7fff, 0, '0},
    '{16'h8000, 16'h7fff, 16'h8000, 0, '0},
    '{16'h0001, 16'h0001, 16'h0001, 0, '0},
    '{16'hffff, 16'h0001, 16'hffff, 0, '0},
    '{16'h0001, 16'h0001, 16'h0000, 0, '0},
    '{16'h0003, 16'hfffc, 16'h0000, 0, '0},
    '{16'h0100, 16'h0200, 16'hfe00, 0, '0},
    '{16'h5555, 16'haaaa, 16'h1234, 0, '0},
    '{16'h0000, 16'h0001, 16'h7fff, 0, '0}
  };

  // offer one item and hold it until the handshake
  task automatic send_vec(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_comp_x <= x;
    in_comp_y <= y;
    in_comp_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // random component: mostly full range, some tiny, some at the rails
  function automatic logic [15:0] rand_comp();
    case ($urandom_range(9))
      0: return 16'($signed($urandom_range(6)) - 3);
      1: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver side: random stalls, plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n || out_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  initial begin
    wait (rst_n);
    repeat (150) @(negedge clk);
    out_hold = 1'b1;
    repeat (300) @(negedge clk);  // block fills and stalls in_ready
    out_hold = 1'b0;
  end

  // scoreboard: every taken item against the oldest expected result
  always @(posedge clk) begin
    norm_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (norm_q.size() == 0) begin
        $error("result with no expected item pending");
        n_fail++;
      end else begin
        exp_r = norm_q.pop_front();
        if (out_unit_x !== exp_r.ux) begin
          $error("unit_x expected %0h actual %0h", exp_r.ux, out_unit_x); n_fail++;
        end
        if (out_unit_y !== exp_r.uy) begin
          $error("unit_y expected %0h actual %0h", exp_r.uy, out_unit_y); n_fail++;
        end
        if (out_unit_z !== exp_r.uz) begin
          $error("unit_z expected %0h actual %0h", exp_r.uz, out_unit_z); n_fail++;
        end
        if (out_magnitude !== exp_r.mag) begin
          $error("magnitude expected %0d actual %0d", exp_r.mag, out_magnitude); n_fail++;
        end
        if (out_zero_vector !== exp_r.zv) begin
          $error("zero_vector expected %0b actual %0b", exp_r.zv, out_zero_vector);
          n_fail++;
        end
      end
    end
  end

  // expectation is queued at acceptance
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      norm_q.push_back(normalize(in_comp_x, in_comp_y, in_comp_z));
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // cross-check typed rows against the predictor once, up front
  initial begin
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].known &&
          normalize(dir_tbl[i].x, dir_tbl[i].y, dir_tbl[i].z) !== dir_tbl[i].res) begin
        $error("directed row %0d: typed result disagrees with predictor", i);
        n_fail++;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (dir_tbl[i]) send_vec(dir_tbl[i].x, dir_tbl[i].y, dir_tbl[i].z);
    for (int i = 0; i < N_RANDOM; i++) begin
      // three idling phases over the random part
      if (i == N_RANDOM / 3) begin
        in_idle_pct  = 70;
        out_idle_pct = 27;
      end else if (i == 2 * N_RANDOM / 3) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      send_vec(rand_comp(), rand_comp(), rand_comp());
    end
    in_valid <= 1'b0;
    while (norm_q.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES + 10) @(posedge clk);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
